// ----- hw/rtl/assert_macros.svh -----
// Assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, prop)
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ----- hw/rtl/bdcc_pkg.sv -----
package bdcc_pkg;

  localparam int unsigned RawW  = 10;
  localparam int unsigned PixW  = 8;
  localparam int unsigned GainW = 11;
  localparam int unsigned ProdW = PixW + GainW;

  localparam logic [PixW-1:0] BlackLevel = 8'd16;

  localparam logic [1:0] CFG_GAIN_RED   = 2'd0;
  localparam logic [1:0] CFG_GAIN_GREEN = 2'd1;
  localparam logic [1:0] CFG_GAIN_BLUE  = 2'd2;

  // first member sits in the top bits, so ul lands in the lowest bits
  typedef struct packed {
    logic [RawW-1:0] dr;
    logic [RawW-1:0] d;
    logic [RawW-1:0] dl;
    logic [RawW-1:0] r;
    logic [RawW-1:0] c;
    logic [RawW-1:0] l;
    logic [RawW-1:0] ur;
    logic [RawW-1:0] u;
    logic [RawW-1:0] ul;
  } win_t;

  typedef struct packed {
    logic [PixW-1:0] blue;
    logic [PixW-1:0] green;
    logic [PixW-1:0] red;
  } rgb_t;

  typedef struct packed {
    logic [GainW-1:0] blue;
    logic [GainW-1:0] green;
    logic [GainW-1:0] red;
  } gains_t;

  typedef struct packed {
    logic [ProdW-1:0] blue;
    logic [ProdW-1:0] green;
    logic [ProdW-1:0] red;
  } prod_t;

  typedef logic [PixW-1:0] gamma_lut_t [256];

  // floor(sqrt(v*255)), evaluated at elaboration only
  function automatic gamma_lut_t gamma_build();
    gamma_lut_t lut;
    int         r;
    for (int v = 0; v < 256; v++) begin
      r = 0;
      while ((r + 1) * (r + 1) <= v * 255) r++;
      lut[v] = PixW'(r);
    end
    return lut;
  endfunction

  localparam gamma_lut_t GammaLut = gamma_build();

endpackage

// ----- hw/rtl/bdcc_interp.sv -----
module bdcc_interp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  bdcc_pkg::win_t win_i,
  input  logic           x_odd_i,
  input  logic           y_odd_i,
  output logic           valid_o,
  input  logic           ready_i,
  output bdcc_pkg::rgb_t rgb_o
);

  logic [7:0] ul, u, ur, l, c, r, dl, d, dr;
  logic [7:0] diag4, cross4, vert2, horz2;
  logic [9:0] diag_sum, cross_sum;
  logic [8:0] vert_sum, horz_sum;
  logic       valid_q;
  bdcc_pkg::rgb_t rgb_d, rgb_q;

  assign ul = win_i.ul[9:2];
  assign u  = win_i.u[9:2];
  assign ur = win_i.ur[9:2];
  assign l  = win_i.l[9:2];
  assign c  = win_i.c[9:2];
  assign r  = win_i.r[9:2];
  assign dl = win_i.dl[9:2];
  assign d  = win_i.d[9:2];
  assign dr = win_i.dr[9:2];

  assign diag_sum  = 10'(ul) + 10'(ur) + 10'(dl) + 10'(dr) + 10'd2;
  assign cross_sum = 10'(l) + 10'(r) + 10'(u) + 10'(d) + 10'd2;
  assign vert_sum  = 9'(u) + 9'(d) + 9'd1;
  assign horz_sum  = 9'(l) + 9'(r) + 9'd1;
  assign diag4  = diag_sum[9:2];
  assign cross4 = cross_sum[9:2];
  assign vert2  = vert_sum[8:1];
  assign horz2  = horz_sum[8:1];

  always_comb begin
    case ({y_odd_i, x_odd_i})
      2'b00: begin
        rgb_d.red = diag4;  rgb_d.green = cross4; rgb_d.blue = c;
      end
      2'b01: begin
        rgb_d.red = vert2;  rgb_d.green = c;      rgb_d.blue = horz2;
      end
      2'b10: begin
        rgb_d.red = horz2;  rgb_d.green = c;      rgb_d.blue = vert2;
      end
      default: begin
        rgb_d.red = c;      rgb_d.green = cross4; rgb_d.blue = diag4;
      end
    endcase
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rgb_q <= rgb_d;
    end
  end

  assign valid_o = valid_q;
  assign rgb_o   = rgb_q;

endmodule

// ----- hw/rtl/bdcc_gain.sv -----
module bdcc_gain (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  bdcc_pkg::rgb_t   rgb_i,
  input  bdcc_pkg::gains_t gains_i,
  output logic             valid_o,
  input  logic             ready_i,
  output bdcc_pkg::prod_t  prod_o
);

  localparam int unsigned PW = bdcc_pkg::ProdW;

  logic [bdcc_pkg::PixW-1:0] lin_r, lin_g, lin_b;
  logic                      valid_q;
  bdcc_pkg::prod_t           prod_d, prod_q;

  // black level removal, floor at zero
  assign lin_r = (rgb_i.red   > bdcc_pkg::BlackLevel) ? rgb_i.red   - bdcc_pkg::BlackLevel : '0;
  assign lin_g = (rgb_i.green > bdcc_pkg::BlackLevel) ? rgb_i.green - bdcc_pkg::BlackLevel : '0;
  assign lin_b = (rgb_i.blue  > bdcc_pkg::BlackLevel) ? rgb_i.blue  - bdcc_pkg::BlackLevel : '0;

  assign prod_d.red   = PW'(lin_r) * PW'(gains_i.red);
  assign prod_d.green = PW'(lin_g) * PW'(gains_i.green);
  assign prod_d.blue  = PW'(lin_b) * PW'(gains_i.blue);

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      prod_q <= prod_d;
    end
  end

  assign valid_o = valid_q;
  assign prod_o  = prod_q;

endmodule

// ----- hw/rtl/bdcc_gamma.sv -----
module bdcc_gamma (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  bdcc_pkg::prod_t prod_i,
  output logic            valid_o,
  input  logic            ready_i,
  output bdcc_pkg::rgb_t  rgb_o
);

  logic [7:0]     cor_r, cor_g, cor_b;
  logic           valid_q;
  bdcc_pkg::rgb_t rgb_d, rgb_q;

  // divide by 256, saturate at 255
  assign cor_r = (|prod_i.red[18:16])   ? 8'hFF : prod_i.red[15:8];
  assign cor_g = (|prod_i.green[18:16]) ? 8'hFF : prod_i.green[15:8];
  assign cor_b = (|prod_i.blue[18:16])  ? 8'hFF : prod_i.blue[15:8];

  assign rgb_d.red   = bdcc_pkg::GammaLut[cor_r];
  assign rgb_d.green = bdcc_pkg::GammaLut[cor_g];
  assign rgb_d.blue  = bdcc_pkg::GammaLut[cor_b];

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rgb_q <= rgb_d;
    end
  end

  assign valid_o = valid_q;
  assign rgb_o   = rgb_q;

endmodule

// ----- hw/rtl/bayer_demosaic_color_correct.sv -----
// Channel  Dir  Item
// s_axis   in   3x3 raw BGGR window (tdata) and centre parity (tuser)
// m_axis   out  RGB888 plus RGB565 of the centre pixel
// cfg      in   gain write: index 0 red, 1 green, 2 blue
//
// One item per cycle unless the output stalls; stages (interpolate,
// gain multiply, saturate and gamma ROM) are each a registered slot.
// Reset clears the stage valid bits and sets all gains to 1.0 (256).
// A stall holds the output slot; upstream slots keep filling until full.
`include "assert_macros.svh"

module bayer_demosaic_color_correct (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // sample_up_left, sample_up, sample_up_right, sample_left, center_sample,
  // sample_right, sample_down_left, sample_down, sample_down_right, zero pad
  input  logic [95:0] s_axis_tdata,
  // x_odd, y_odd
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // red, green, blue, pixel_565
  output logic [39:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [10:0] cfg_data_i
);

  bdcc_pkg::gains_t gains_q;
  bdcc_pkg::win_t   win;
  bdcc_pkg::rgb_t   interp_rgb, out_rgb;
  bdcc_pkg::prod_t  prod;
  logic             interp_valid, interp_ready;
  logic             gain_valid, gain_ready;
  logic [15:0]      pixel_565;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q.red   <= 11'd256;
      gains_q.green <= 11'd256;
      gains_q.blue  <= 11'd256;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        bdcc_pkg::CFG_GAIN_RED:   gains_q.red   <= cfg_data_i;
        bdcc_pkg::CFG_GAIN_GREEN: gains_q.green <= cfg_data_i;
        bdcc_pkg::CFG_GAIN_BLUE:  gains_q.blue  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign win = s_axis_tdata[89:0];

  bdcc_interp u_interp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .win_i   (win),
    .x_odd_i (s_axis_tuser[0]),
    .y_odd_i (s_axis_tuser[1]),
    .valid_o (interp_valid),
    .ready_i (interp_ready),
    .rgb_o   (interp_rgb)
  );

  bdcc_gain u_gain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (interp_valid),
    .ready_o (interp_ready),
    .rgb_i   (interp_rgb),
    .gains_i (gains_q),
    .valid_o (gain_valid),
    .ready_i (gain_ready),
    .prod_o  (prod)
  );

  bdcc_gamma u_gamma (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (gain_valid),
    .ready_o (gain_ready),
    .prod_i  (prod),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .rgb_o   (out_rgb)
  );

  assign pixel_565    = {out_rgb.red[7:3], out_rgb.green[7:2], out_rgb.blue[7:3]};
  assign m_axis_tdata = {pixel_565, out_rgb.blue, out_rgb.green, out_rgb.red};

  `ASSERT_IMPLIES(a_empty_out_accepts, clk_i, rst_ni, !m_axis_tvalid, s_axis_tready)
  `ASSERT_NEXT(a_accept_fills_stage, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, interp_valid)
  `ASSERT_NEXT(a_red_gain_write, clk_i, rst_ni,
               cfg_we_i && cfg_index_i == bdcc_pkg::CFG_GAIN_RED,
               gains_q.red == $past(cfg_data_i))
  `ASSERT_ALWAYS(a_stall_chain, clk_i, rst_ni, !gain_ready || interp_ready)

endmodule

// ----- bench/bdcc_checker.sv -----
`timescale 1ns / 100ps

module bdcc_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  // sample_up_left, sample_up, sample_up_right, sample_left, center_sample,
  // sample_right, sample_down_left, sample_down, sample_down_right, zero pad
  input  logic [95:0] s_axis_tdata,
  // x_odd, y_odd
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // red, green, blue, pixel_565
  input  logic [39:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [10:0] cfg_data_i,
  output int          err_count_o,
  output int          pending_o,
  output int          matched_o
);
  import bdcc_pkg::*;

  typedef struct packed {
    logic [15:0] pix565;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
  } pixel_t;

  // index is {y_odd, x_odd}
  typedef enum logic [1:0] {
    SITE_BLUE       = 2'b00,
    SITE_GREEN_BROW = 2'b01,
    SITE_GREEN_RROW = 2'b10,
    SITE_RED        = 2'b11
  } site_e;

  logic [GainW-1:0] gain_r, gain_g, gain_b;
  pixel_t           expected_px[$];
  pixel_t           got_px, want_px;

  function automatic logic [7:0] avg2(logic [7:0] a, logic [7:0] b);
    int unsigned s;
    s = a + b + 1;
    return 8'(s / 2);
  endfunction

  function automatic logic [7:0] avg4(logic [7:0] a, logic [7:0] b,
                                      logic [7:0] c, logic [7:0] d);
    int unsigned s;
    s = a + b + c + d + 2;
    return 8'(s / 4);
  endfunction

  // floor(sqrt(v*255)), bit by bit from the top
  function automatic logic [7:0] gamma_encode(int unsigned v);
    int unsigned root, trial, prod;
    root = 0;
    prod = v * 255;
    for (int b = 7; b >= 0; b--) begin
      trial = root | (32'd1 << b);
      if (trial * trial <= prod) root = trial;
    end
    return 8'(root);
  endfunction

  function automatic logic [7:0] balance_channel(logic [7:0] v, logic [GainW-1:0] g);
    int unsigned lin, cor;
    lin = (v > BlackLevel) ? v - BlackLevel : 0;
    cor = lin * g / 256;
    if (cor > 255) cor = 255;
    return gamma_encode(cor);
  endfunction

  function automatic pixel_t demosaic_pixel(win_t w, logic [1:0] par);
    logic [7:0] ul, u, ur, l, c, r, dl, d, dr, rr, gg, bb;
    pixel_t     p;
    ul = w.ul[9:2]; u = w.u[9:2]; ur = w.ur[9:2];
    l  = w.l[9:2];  c = w.c[9:2]; r  = w.r[9:2];
    dl = w.dl[9:2]; d = w.d[9:2]; dr = w.dr[9:2];
    case (site_e'(par))
      SITE_BLUE: begin
        rr = avg4(ul, ur, dl, dr);
        gg = avg4(l, r, u, d);
        bb = c;
      end
      SITE_GREEN_BROW: begin
        rr = avg2(u, d);
        gg = c;
        bb = avg2(l, r);
      end
      SITE_GREEN_RROW: begin
        rr = avg2(l, r);
        gg = c;
        bb = avg2(u, d);
      end
      default: begin
        rr = c;
        gg = avg4(l, r, u, d);
        bb = avg4(ul, ur, dl, dr);
      end
    endcase
    p.red    = balance_channel(rr, gain_r);
    p.green  = balance_channel(gg, gain_g);
    p.blue   = balance_channel(bb, gain_b);
    p.pix565 = {p.red[7:3], p.green[7:2], p.blue[7:3]};
    return p;
  endfunction

  task automatic report(string msg);
    err_count_o++;
    $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) report($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_r = 11'd256;
      gain_g = 11'd256;
      gain_b = 11'd256;
      expected_px.delete();
      err_count_o = 0;
      pending_o   = 0;
      matched_o   = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_px = m_axis_tdata;
        if (expected_px.size() == 0) begin
          report($sformatf("pixel 0x%010h with no item waiting", m_axis_tdata));
        end else begin
          want_px = expected_px.pop_front();
          check_field("red", 16'(got_px.red), 16'(want_px.red));
          check_field("green", 16'(got_px.green), 16'(want_px.green));
          check_field("blue", 16'(got_px.blue), 16'(want_px.blue));
          check_field("pixel_565", got_px.pix565, want_px.pix565);
          matched_o++;
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_px.push_back(demosaic_pixel(win_t'(s_axis_tdata[89:0]), s_axis_tuser));
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_GAIN_RED:   gain_r = cfg_data_i;
          CFG_GAIN_GREEN: gain_g = cfg_data_i;
          CFG_GAIN_BLUE:  gain_b = cfg_data_i;
          default: ;
        endcase
      end
      pending_o = expected_px.size();
    end
  end

endmodule

// ----- bench/bayer_demosaic_color_correct_tb.sv -----
`timescale 1ns / 100ps

module bayer_demosaic_color_correct_tb;
  import bdcc_pkg::*;

  localparam logic [1:0] CfgSpare = 2'd3;
  localparam int PhaseCount    = 8;
  localparam int RandomItems   = 1950;
  localparam int TimeoutCycles = 300000;
  localparam int HoldCycles    = 90;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [10:0] cfg_data_i = '0;

  int err_count, pending, matched;
  int items_sent = 0;
  int gain_settings = 1;
  int holds_done = 0;

  bayer_demosaic_color_correct dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_index_i, .cfg_data_i
  );

  bdcc_checker checker_i (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .err_count_o(err_count), .pending_o(pending), .matched_o(matched)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < TimeoutCycles) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout, %0d pixels outstanding", pending);
    $display("RESULT: ERROR");
    $finish;
  end

  // receiver: changing stall pattern, plus long hold-offs to back up the pipe
  initial begin : receiver
    int rx_cycle, rx_mode, hold_left;
    int hold_marks[2];
    logic rdy;
    rx_cycle = 0;
    rx_mode = 0;
    hold_left = 0;
    hold_marks[0] = 600;
    hold_marks[1] = 1400;
    forever begin
      @(negedge clk_i);
      rx_cycle++;
      if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
      if (hold_left == 0 && holds_done < 2 && items_sent >= hold_marks[holds_done]) begin
        hold_left = HoldCycles;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        case (rx_mode)
          0: rdy = 1'b1;
          1: rdy = 1'($urandom_range(0, 1));
          2: rdy = ($urandom_range(0, 9) != 0);
          default: rdy = (rx_cycle % 3 == 0);
        endcase
      end
      m_axis_tready <= rdy;
    end
  end

  function automatic win_t mk_win(logic [9:0] ul, logic [9:0] u, logic [9:0] ur,
                                  logic [9:0] l, logic [9:0] c, logic [9:0] r,
                                  logic [9:0] dl, logic [9:0] d, logic [9:0] dr);
    win_t w;
    w.ul = ul; w.u = u; w.ur = ur;
    w.l  = l;  w.c = c; w.r  = r;
    w.dl = dl; w.d = d; w.dr = dr;
    return w;
  endfunction

  function automatic logic [9:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 10'($urandom_range(0, 7));
      1: return 10'($urandom_range(1016, 1023));
      2: return 10'($urandom_range(60, 75));
      default: return 10'($urandom_range(0, 1023));
    endcase
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic offer(win_t w, logic [1:0] par);
    s_axis_tdata  <= {6'd0, w};
    s_axis_tuser  <= par;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic pause(int n);
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  task automatic flat(logic [9:0] v, logic [1:0] par);
    offer(mk_win(v, v, v, v, v, v, v, v, v), par);
  endtask

  task automatic random_window(output win_t w);
    logic [9:0] v;
    if ($urandom_range(0, 7) == 0) begin
      v = pick_sample();
      w = mk_win(v, v, v, v, v, v, v, v, v);
    end else begin
      w = mk_win(pick_sample(), pick_sample(), pick_sample(),
                 pick_sample(), pick_sample(), pick_sample(),
                 pick_sample(), pick_sample(), pick_sample());
    end
  endtask

  task automatic run_random(int n);
    int   sent, burst;
    win_t w;
    sent = 0;
    while (sent < n) begin
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
      for (int i = 0; i < burst && sent < n; i++) begin
        random_window(w);
        offer(w, 2'($urandom_range(0, 3)));
        sent++;
      end
      pause($urandom_range(0, 6));
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic set_gains(logic [10:0] r, logic [10:0] g, logic [10:0] b);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_GAIN_RED;
    cfg_data_i  <= r;
    @(negedge clk_i);
    cfg_index_i <= CFG_GAIN_GREEN;
    cfg_data_i  <= g;
    @(negedge clk_i);
    cfg_index_i <= CFG_GAIN_BLUE;
    cfg_data_i  <= b;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    gain_settings++;
  endtask

  initial begin : stimulus
    int per_phase;
    per_phase = RandomItems / PhaseCount;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int p = 0; p < 4; p++) begin
      flat(10'd0, 2'(p));
      flat(10'd1023, 2'(p));
    end
    // rounding of two- and four-way means, low bits dropped
    for (int p = 0; p < 4; p++)
      offer(mk_win(10'd1023, 10'd7, 10'd3, 10'd8, 10'd513, 10'd6, 10'd14, 10'd11, 10'd5),
            2'(p));
    // just at and above the black level
    flat(10'd67, 2'd0);
    flat(10'd68, 2'd3);
    offer(mk_win(10'd800, 10'd1000, 10'd900, 10'd850, 10'd950, 10'd999, 10'd820, 10'd870,
                 10'd910), 2'd1);
    offer(mk_win(10'd910, 10'd870, 10'd820, 10'd999, 10'd950, 10'd850, 10'd900, 10'd1000,
                 10'd800), 2'd2);
    drain();

    // out-of-range index must leave every gain alone
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CfgSpare;
    cfg_data_i  <= 11'h7ff;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;

    for (int ph = 0; ph < PhaseCount; ph++) begin
      case (ph)
        0: ;
        1: set_gains(11'd128, 11'd128, 11'd128);
        2: set_gains(11'd1024, 11'd1024, 11'd1024);
        3: set_gains(11'd0, 11'd2047, 11'd1);
        4: set_gains(11'd2047, 11'd0, 11'd2047);
        6: set_gains(11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)),
                     11'($urandom_range(0, 2047)));
        default: set_gains(11'($urandom_range(128, 1024)), 11'($urandom_range(128, 1024)),
                           11'($urandom_range(128, 1024)));
      endcase
      run_random(per_phase);
      drain();
    end
    repeat (10) @(negedge clk_i);

    $display("run: %0d windows over all four Bayer sites, %0d pixels checked", items_sent,
             matched);
    $display("     %0d gain settings incl. 0 and 2047, %0d long output hold-offs",
             gain_settings, holds_done);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", err_count);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/bdcc_pkg.sv
hw/rtl/bdcc_interp.sv
hw/rtl/bdcc_gain.sv
hw/rtl/bdcc_gamma.sv
hw/rtl/bayer_demosaic_color_correct.sv
bench/bdcc_checker.sv
bench/bayer_demosaic_color_correct_tb.sv
